FILE: rtl/core/pointwise_list_averager_defines.svh
// assertion macros for the pointwise list averager
// included by files that carry concurrent checks, no other dependencies
`ifndef POINTWISE_LIST_AVERAGER_DEFINES_SVH
`define POINTWISE_LIST_AVERAGER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PLA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pointwise_list_averager: check failed");

// next-cycle implication, disabled while reset is asserted
`define PLA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pointwise_list_averager: check failed");

`endif

FILE: rtl/core/pla_pkg.sv
// shared types and constants for the pointwise list averager
// no dependencies
package pla_pkg;

    localparam int ROWS_DEF = 32;
    localparam int COLS_DEF = 16;

    localparam int PT_W  = 16;
    localparam int SUM_W = 21;
    localparam int AVG_W = 16;

    localparam int AVG_POS_MAX = 32767;
    localparam int AVG_NEG_MAG = 32768;

    typedef enum logic {
        CMD_POINT   = 1'b0,
        CMD_READOUT = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_ROW_AVG    = 3'd0,
        ST_LIST_OK    = 3'd1,
        ST_LIST_REJ   = 3'd2,
        ST_LIST_TRUNC = 3'd3,
        ST_EMPTY      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_RREAD,
        S_RLOAD,
        S_RDIV
    } t_state;

endpackage

FILE: rtl/core/pla_sum_mem.sv
// per-row x/y sum store, one read and one write port, registered read
// rows not yet written read as zero through reset-cleared valid bits; uses pla_pkg
module pla_sum_mem import pla_pkg::*; #(
    parameter int ROWS = ROWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rd_en,
    input  logic [(ROWS>1?$clog2(ROWS):1)-1:0] i_rd_addr,
    output logic signed [SUM_W-1:0]         o_rd_x,
    output logic signed [SUM_W-1:0]         o_rd_y,
    input  logic                            i_wr_en,
    input  logic [(ROWS>1?$clog2(ROWS):1)-1:0] i_wr_addr,
    input  logic signed [SUM_W-1:0]         i_wr_x,
    input  logic signed [SUM_W-1:0]         i_wr_y
);

    logic [2*SUM_W-1:0] r_mem [ROWS];
    logic [ROWS-1:0]    r_valid;
    logic [2*SUM_W-1:0] r_rd_data;
    logic               r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_x, i_wr_y};
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_valid[i_rd_addr];
            end
        end
    end

    // unwritten rows read as zero through their cleared valid bit
    assign o_rd_x = r_rd_vld ? r_rd_data[2*SUM_W-1:SUM_W] : '0;
    assign o_rd_y = r_rd_vld ? r_rd_data[SUM_W-1:0]       : '0;

endmodule

FILE: rtl/core/pla_rdiv.sv
// iterative rounded average: sum / count, half away from zero, saturated to 16 bits
// one quotient bit per cycle, restoring; uses pla_pkg
module pla_rdiv import pla_pkg::*; #(
    parameter int CNT_W = $clog2(COLS_DEF + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  logic signed [SUM_W-1:0] i_sum,
    input  logic [CNT_W-1:0]        i_div,
    output logic                    o_done,
    output logic signed [AVG_W-1:0] o_avg
);

    localparam int NUM_W = SUM_W + 2;
    localparam int DEN_W = CNT_W + 1;
    localparam int IT_W  = $clog2(NUM_W);

    logic [NUM_W-1:0]        r_num;
    logic [DEN_W-1:0]        r_rem;
    logic [DEN_W-1:0]        r_den;
    logic                    r_neg;
    logic [IT_W-1:0]         r_cnt;
    logic                    r_run;
    logic                    r_done;
    logic signed [AVG_W-1:0] r_avg;

    logic [SUM_W-1:0]        w_mag;
    logic [NUM_W-1:0]        w_num_init;
    logic [DEN_W:0]          w_rem_sh;
    logic                    w_ge;
    logic [DEN_W-1:0]        w_rem_nx;
    logic [NUM_W-1:0]        w_quo;
    logic signed [AVG_W-1:0] w_avg_sat;
    logic                    w_last_step;

    // numerator 2*|s| + d over denominator 2*d gives round half away from zero
    assign w_mag      = i_sum[SUM_W-1] ? SUM_W'(-i_sum) : SUM_W'(i_sum);
    assign w_num_init = {1'b0, w_mag, 1'b0} + NUM_W'(i_div);

    assign w_rem_sh = {r_rem, r_num[NUM_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_nx = w_ge ? DEN_W'(w_rem_sh - {1'b0, r_den}) : w_rem_sh[DEN_W-1:0];
    assign w_quo    = {r_num[NUM_W-2:0], w_ge};

    assign w_last_step = r_run && (r_cnt == IT_W'(NUM_W - 1));

    always_comb begin
        if (!r_neg) begin
            w_avg_sat = (w_quo > NUM_W'(AVG_POS_MAX)) ? AVG_W'(AVG_POS_MAX)
                                                      : w_quo[AVG_W-1:0];
        end else begin
            w_avg_sat = (w_quo > NUM_W'(AVG_NEG_MAG)) ? AVG_W'(AVG_NEG_MAG)
                                                      : AVG_W'(~w_quo[AVG_W-1:0] + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (w_last_step) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_num <= w_num_init;
            r_rem <= '0;
            r_den <= {i_div, 1'b0};
            r_neg <= i_sum[SUM_W-1];
        end else if (r_run) begin
            r_num <= w_quo;
            r_rem <= w_rem_nx;
        end
        if (w_last_step) begin
            r_avg <= w_avg_sat;
        end
    end

    assign o_done = r_done;
    assign o_avg  = r_avg;

endmodule

FILE: rtl/core/pointwise_list_averager.sv
// point step: accept, then sum read-modify-write in S_ADD before the next point; list result in the cycle after accept
// readout per row: memory read, divider load, 23 divider steps, result; ROWS rows
// empty readout: one result in the cycle after accept, busy stays low
// results cannot be stalled: each shows for one cycle with o_valid
// synchronous active-low reset clears counters, flags and row valid bits, so all sums read zero
`include "pointwise_list_averager_defines.svh"
module pointwise_list_averager import pla_pkg::*; #(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_command,
    input  logic signed [PT_W-1:0]  i_point_x,
    input  logic signed [PT_W-1:0]  i_point_y,
    input  logic                    i_end_of_list,
    output logic                    o_valid,
    output logic signed [AVG_W-1:0] o_avg_x,
    output logic signed [AVG_W-1:0] o_avg_y,
    output logic [2:0]              o_status,
    output logic                    o_last_result
);

    localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int POS_W  = $clog2(ROWS + 1);
    localparam int CNT_W  = $clog2(COLS + 1);

    // control state
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_lists, n_lists;
    logic [POS_W-1:0]    r_pos,   n_pos;
    logic                r_rej,   n_rej;
    logic                r_trunc, n_trunc;
    logic [ADDR_W-1:0]   r_row,   n_row;
    logic                r_out_valid, n_out_valid;

    // payload registers
    logic signed [AVG_W-1:0] r_avg_x, n_avg_x;
    logic signed [AVG_W-1:0] r_avg_y, n_avg_y;
    t_status                 r_status, n_status;
    logic                    r_last, n_last;
    logic signed [PT_W-1:0]  r_px, n_px;
    logic signed [PT_W-1:0]  r_py, n_py;
    logic                    r_add, n_add;
    logic [ADDR_W-1:0]       r_wr_addr, n_wr_addr;

    // memory and divider hookup
    logic                    w_rd_en;
    logic [ADDR_W-1:0]       w_rd_addr;
    logic signed [SUM_W-1:0] w_rd_x, w_rd_y;
    logic                    w_wr_en;
    logic signed [SUM_W-1:0] w_wr_x, w_wr_y;
    logic                    w_div_load;
    logic                    w_done_x, w_done_y;
    logic signed [AVG_W-1:0] w_q_x, w_q_y;

    logic w_accept;
    logic w_rej;
    logic w_in_range;
    logic w_trunc;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && (r_state == S_IDLE);

    // a list that opens with the store full is rejected as a whole
    assign w_rej      = r_rej || ((r_pos == '0) && (r_lists >= CNT_W'(COLS)));
    assign w_in_range = (r_pos < POS_W'(ROWS));
    // points past the last row are dropped and mark the list
    assign w_trunc    = r_trunc || (!w_rej && !w_in_range);

    // read-modify-write of the row sum, data read at accept arrives in S_ADD
    assign w_wr_en = (r_state == S_ADD) && r_add;
    assign w_wr_x  = w_rd_x + {{(SUM_W-PT_W){r_px[PT_W-1]}}, r_px};
    assign w_wr_y  = w_rd_y + {{(SUM_W-PT_W){r_py[PT_W-1]}}, r_py};

    pla_sum_mem #(
        .ROWS (ROWS)
    ) u_sum_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_x    (w_rd_x),
        .o_rd_y    (w_rd_y),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_wr_addr),
        .i_wr_x    (w_wr_x),
        .i_wr_y    (w_wr_y)
    );

    // x and y dividers run in lockstep on the same count
    pla_rdiv #(
        .CNT_W (CNT_W)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_div_load),
        .i_sum   (w_rd_x),
        .i_div   (r_lists),
        .o_done  (w_done_x),
        .o_avg   (w_q_x)
    );

    pla_rdiv #(
        .CNT_W (CNT_W)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_div_load),
        .i_sum   (w_rd_y),
        .i_div   (r_lists),
        .o_done  (w_done_y),
        .o_avg   (w_q_y)
    );

    always_comb begin
        n_state     = r_state;
        n_lists     = r_lists;
        n_pos       = r_pos;
        n_rej       = r_rej;
        n_trunc     = r_trunc;
        n_row       = r_row;
        n_out_valid = 1'b0;
        n_avg_x     = r_avg_x;
        n_avg_y     = r_avg_y;
        n_status    = r_status;
        n_last      = r_last;
        n_px        = r_px;
        n_py        = r_py;
        n_add       = r_add;
        n_wr_addr   = r_wr_addr;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_pos[ADDR_W-1:0];
        w_div_load  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_command == CMD_READOUT) begin
                        if (r_lists == '0) begin
                            // nothing stored: single empty word
                            n_out_valid = 1'b1;
                            n_avg_x     = '0;
                            n_avg_y     = '0;
                            n_status    = ST_EMPTY;
                            n_last      = 1'b1;
                        end else begin
                            n_row   = '0;
                            n_state = S_RREAD;
                        end
                    end else begin
                        // point: fetch the row sum now, add and write back in S_ADD
                        w_rd_en   = w_in_range && !w_rej;
                        n_add     = w_in_range && !w_rej;
                        n_wr_addr = r_pos[ADDR_W-1:0];
                        n_px      = i_point_x;
                        n_py      = i_point_y;
                        n_state   = S_ADD;
                        if (i_end_of_list) begin
                            n_out_valid = 1'b1;
                            n_avg_x     = '0;
                            n_avg_y     = '0;
                            n_last      = 1'b1;
                            if (w_rej) begin
                                n_status = ST_LIST_REJ;
                            end else if (w_trunc) begin
                                n_status = ST_LIST_TRUNC;
                            end else begin
                                n_status = ST_LIST_OK;
                            end
                            n_lists = r_lists + CNT_W'(!w_rej);
                            n_pos   = '0;
                            n_rej   = 1'b0;
                            n_trunc = 1'b0;
                        end else begin
                            n_pos   = w_in_range ? r_pos + 1'b1 : r_pos;
                            n_rej   = w_rej;
                            n_trunc = w_trunc;
                        end
                    end
                end
            end
            S_ADD: begin
                n_state = S_IDLE;
            end
            S_RREAD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_row;
                n_state   = S_RLOAD;
            end
            S_RLOAD: begin
                w_div_load = 1'b1;
                n_state    = S_RDIV;
            end
            S_RDIV: begin
                if (w_done_x && w_done_y) begin
                    n_out_valid = 1'b1;
                    n_avg_x     = w_q_x;
                    n_avg_y     = w_q_y;
                    n_status    = ST_ROW_AVG;
                    n_last      = (r_row == ADDR_W'(ROWS - 1));
                    if (r_row == ADDR_W'(ROWS - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_row   = r_row + 1'b1;
                        n_state = S_RREAD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lists     <= '0;
            r_pos       <= '0;
            r_rej       <= 1'b0;
            r_trunc     <= 1'b0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lists     <= n_lists;
            r_pos       <= n_pos;
            r_rej       <= n_rej;
            r_trunc     <= n_trunc;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_avg_x   <= n_avg_x;
        r_avg_y   <= n_avg_y;
        r_status  <= n_status;
        r_last    <= n_last;
        r_px      <= n_px;
        r_py      <= n_py;
        r_add     <= n_add;
        r_wr_addr <= n_wr_addr;
    end

    assign o_valid       = r_out_valid;
    assign o_avg_x       = r_avg_x;
    assign o_avg_y       = r_avg_y;
    assign o_status      = r_status;
    assign o_last_result = r_last;

    // stored list count never passes the column limit
    `PLA_ASSERT_IMP(a_lists_bound, i_clk, i_rst_n, 1'b1, r_lists <= CNT_W'(COLS))
    // an accepted point always gets its write-back cycle
    `PLA_ASSERT_NXT(a_point_rmw, i_clk, i_rst_n, start && !busy && i_command == CMD_POINT, busy && r_state == S_ADD)
    // x and y dividers finish together
    `PLA_ASSERT_IMP(a_div_lockstep, i_clk, i_rst_n, w_done_x || w_done_y, w_done_x && w_done_y)
    // list and empty words are single, final and carry zero averages
    `PLA_ASSERT_IMP(a_status_word, i_clk, i_rst_n, o_valid && o_status != ST_ROW_AVG, o_last_result && o_avg_x == '0 && o_avg_y == '0)

endmodule
